[rtl/mips_instruction_execute_defines.svh]
// ----------------------------------------------------------------------------
// MIPS instruction execute - assertion macros
// Concurrent check wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef MIPS_INSTRUCTION_EXECUTE_DEFINES_SVH
`define MIPS_INSTRUCTION_EXECUTE_DEFINES_SVH
`ifndef SYNTHESIS
`define MIE_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define MIE_ASSERT_ALWAYS(name, prop, msg) \
   name: assert property (@(posedge clock) prop) else $error(msg);
`else
`define MIE_ASSERT(name, prop, msg)
`define MIE_ASSERT_ALWAYS(name, prop, msg)
`endif
`endif

[rtl/mie_pkg.sv]
// ----------------------------------------------------------------------------
// MIPS instruction execute - package
// Opcode and function codes, reset constants, controller/datapath types.
// ----------------------------------------------------------------------------
package mie_pkg;

   localparam logic [5:0] OP_SPECIAL = 6'd0;
   localparam logic [5:0] OP_REGIMM  = 6'd1;
   localparam logic [5:0] OP_J       = 6'd2;
   localparam logic [5:0] OP_JAL     = 6'd3;
   localparam logic [5:0] OP_BEQ     = 6'd4;
   localparam logic [5:0] OP_BNE     = 6'd5;
   localparam logic [5:0] OP_BLEZ    = 6'd6;
   localparam logic [5:0] OP_BGTZ    = 6'd7;
   localparam logic [5:0] OP_ADDI    = 6'd8;
   localparam logic [5:0] OP_ADDIU   = 6'd9;
   localparam logic [5:0] OP_SLTI    = 6'd10;
   localparam logic [5:0] OP_SLTIU   = 6'd11;
   localparam logic [5:0] OP_ANDI    = 6'd12;
   localparam logic [5:0] OP_ORI     = 6'd13;
   localparam logic [5:0] OP_XORI    = 6'd14;
   localparam logic [5:0] OP_LUI     = 6'd15;
   localparam logic [5:0] OP_LB      = 6'd32;
   localparam logic [5:0] OP_LH      = 6'd33;
   localparam logic [5:0] OP_LW      = 6'd35;
   localparam logic [5:0] OP_LBU     = 6'd36;
   localparam logic [5:0] OP_LHU     = 6'd37;
   localparam logic [5:0] OP_SB      = 6'd40;
   localparam logic [5:0] OP_SH      = 6'd41;
   localparam logic [5:0] OP_SW      = 6'd43;

   localparam logic [5:0] FN_SLL     = 6'd0;
   localparam logic [5:0] FN_SRL     = 6'd2;
   localparam logic [5:0] FN_SRA     = 6'd3;
   localparam logic [5:0] FN_SLLV    = 6'd4;
   localparam logic [5:0] FN_SRLV    = 6'd6;
   localparam logic [5:0] FN_SRAV    = 6'd7;
   localparam logic [5:0] FN_JR      = 6'd8;
   localparam logic [5:0] FN_JALR    = 6'd9;
   localparam logic [5:0] FN_SYSCALL = 6'd12;
   localparam logic [5:0] FN_MFHI    = 6'd16;
   localparam logic [5:0] FN_MTHI    = 6'd17;
   localparam logic [5:0] FN_MFLO    = 6'd18;
   localparam logic [5:0] FN_MTLO    = 6'd19;
   localparam logic [5:0] FN_MULT    = 6'd24;
   localparam logic [5:0] FN_MULTU   = 6'd25;
   localparam logic [5:0] FN_DIV     = 6'd26;
   localparam logic [5:0] FN_DIVU    = 6'd27;
   localparam logic [5:0] FN_ADD     = 6'd32;
   localparam logic [5:0] FN_ADDU    = 6'd33;
   localparam logic [5:0] FN_SUB     = 6'd34;
   localparam logic [5:0] FN_SUBU    = 6'd35;
   localparam logic [5:0] FN_AND     = 6'd36;
   localparam logic [5:0] FN_OR      = 6'd37;
   localparam logic [5:0] FN_XOR     = 6'd38;
   localparam logic [5:0] FN_NOR     = 6'd39;
   localparam logic [5:0] FN_SLT     = 6'd42;
   localparam logic [5:0] FN_SLTU    = 6'd43;

   localparam logic [4:0] RI_BLTZ    = 5'd0;
   localparam logic [4:0] RI_BGEZ    = 5'd1;
   localparam logic [4:0] RI_BLTZAL  = 5'd16;
   localparam logic [4:0] RI_BGEZAL  = 5'd17;

   localparam logic [7:0]  CSR_DATA_BASE   = 8'd1;
   localparam logic [31:0] RESET_PC        = 32'h0040_0000;
   localparam logic [31:0] RESET_DATA_BASE = 32'h1000_0000;
   localparam logic [31:0] HALT_CODE       = 32'd10;
   localparam logic [4:0]  LINK_REG        = 5'd31;
   localparam logic [4:0]  SYSCALL_REG     = 5'd2;

   typedef struct packed {
      logic accept;
      logic clear_en;
      logic ex_en;
      logic idx1_en;
      logic idx2_en;
      logic mrd_en;
      logic div_start;
      logic wb_en;
   } mie_cmd_type;

   typedef struct packed {
      logic is_mem;
      logic is_div;
      logic div_busy;
      logic clear_last;
   } mie_status_type;

endpackage

[rtl/mips_instruction_execute.sv]
// ----------------------------------------------------------------------------
// MIPS instruction execute - top level
// MIPS-I integer core executing one fetched instruction word per transfer.
// ----------------------------------------------------------------------------
// Request channel (req_valid/req_stall) carries one instruction word fetched
// at the last reported next PC. Result channel (rsp_valid/rsp_stall) returns
// one result per instruction: next PC, halt flag, register, HI/LO and store
// effects. The csr port (csr_valid/csr_ready, always ready) sets data_base
// at index 1; index 0 and others are accepted and have no effect.
// ALU, branch, jump and multiply instructions go from execute straight to
// writeback. Loads and stores first map the address into the data store
// through a reciprocal multiply (states IDX1 and IDX2), then read it (MRD).
// Divides wait on the radix-2 divider. One instruction is in flight;
// a new request is taken the cycle after its result is registered.
// After reset a clearing sweep zeroes the data store, with req_stall high
// throughout; PC resets to 0x00400000.
// While rsp_stall holds the result register full, a finished instruction
// waits in writeback and the core takes no further request.
// ----------------------------------------------------------------------------
module mips_instruction_execute import mie_pkg::*; #(
   parameter int DATA_WORDS = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_instr_word,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_next_pc,
   output logic        rsp_halted,
   output logic        rsp_reg_written,
   output logic [4:0]  rsp_reg_index,
   output logic [31:0] rsp_reg_value,
   output logic [31:0] rsp_hi_value,
   output logic [31:0] rsp_lo_value,
   output logic        rsp_store_done,
   output logic [31:0] rsp_store_address,
   output logic [31:0] rsp_store_value,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [31:0] csr_data
);

   mie_cmd_type    cmd;
   mie_status_type status;

   assign csr_ready = 1'b1;

   mie_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   mie_datapath #(
      .DATA_WORDS (DATA_WORDS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .csr_write         (csr_valid & csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_instr_word    (req_instr_word),
      .rsp_next_pc       (rsp_next_pc),
      .rsp_halted        (rsp_halted),
      .rsp_reg_written   (rsp_reg_written),
      .rsp_reg_index     (rsp_reg_index),
      .rsp_reg_value     (rsp_reg_value),
      .rsp_hi_value      (rsp_hi_value),
      .rsp_lo_value      (rsp_lo_value),
      .rsp_store_done    (rsp_store_done),
      .rsp_store_address (rsp_store_address),
      .rsp_store_value   (rsp_store_value)
   );

endmodule

[rtl/mie_divider.sv]
// ----------------------------------------------------------------------------
// MIPS instruction execute - divider
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mie_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [31:0] divisor,
   output logic        busy,
   output logic [31:0] quotient,
   output logic [31:0] remainder
);

   logic        busy_ff, busy_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [31:0] dvs_ff, dvs_in;
   logic [32:0] shifted;
   logic        ge;

   always_comb begin
      shifted = {rem_ff, quo_ff[31]};
      ge      = shifted >= {1'b0, dvs_ff};
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? 32'(shifted - {1'b0, dvs_ff}) : shifted[31:0];
         quo_in = {quo_ff[30:0], ge};
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign busy      = busy_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

[rtl/mie_datapath.sv]
// ----------------------------------------------------------------------------
// MIPS instruction execute - datapath
// Register file, data store, address mapping, ALU, multiplier, divider and writeback.
// ----------------------------------------------------------------------------
module mie_datapath import mie_pkg::*; #(
   parameter int DATA_WORDS = 1024
) (
   input  logic           clock,
   input  logic           reset,
   input  mie_cmd_type    cmd,
   output mie_status_type status,
   input  logic           csr_write,
   input  logic [7:0]     csr_index,
   input  logic [31:0]    csr_data,
   input  logic [31:0]    req_instr_word,
   output logic [31:0]    rsp_next_pc,
   output logic           rsp_halted,
   output logic           rsp_reg_written,
   output logic [4:0]     rsp_reg_index,
   output logic [31:0]    rsp_reg_value,
   output logic [31:0]    rsp_hi_value,
   output logic [31:0]    rsp_lo_value,
   output logic           rsp_store_done,
   output logic [31:0]    rsp_store_address,
   output logic [31:0]    rsp_store_value
);

   localparam int AW = $clog2(DATA_WORDS);
   localparam logic [31:0] RECIP = 32'((64'd1 << 32) / DATA_WORDS);
   localparam logic [AW:0] DEPTH = (AW + 1)'(DATA_WORDS);
   localparam logic [AW-1:0] LAST = AW'(DATA_WORDS - 1);

   logic [31:0] rf_mem [32];
   logic [31:0] store_mem [DATA_WORDS];

   logic [31:0] rf_vld_ff;
   logic [31:0] pc_ff, hi_ff, lo_ff, data_base_ff;
   logic        stopped_ff;
   logic [AW-1:0] clr_ff;
   logic [31:0] instr_ff;
   logic [31:0] rf_a_ff, rf_b_ff;
   logic        a_vld_ff, b_vld_ff;
   logic [31:0] ea_ff;
   logic [29:0] x_ff;
   logic [63:0] prod_ff;
   logic [61:0] prod1_ff;
   logic [AW:0] r0_ff;
   logic [AW-1:0] idx_ff;
   logic [31:0] mem_ff;

   logic [5:0]  req_op, req_fn, op, fn;
   logic [4:0]  ra, rt, rd, sa;
   logic [15:0] imm;
   logic [31:0] a, b, sext, pc4, btarget, jt, off, ea;
   logic [AW:0] idx_c;
   logic [4:0]  bsh, hsh;
   logic [31:0] mem_b, mem_h, mask, sdata;
   logic [31:0] div_q, div_r, div_dnd, div_dvs;
   logic        div_busy, div_signed;
   logic        mul_signed;
   logic signed [65:0] prod_full;

   logic        wr, st;
   logic [4:0]  widx;
   logic [31:0] wval, npc, sval, hi_n, lo_n;
   logic        stop_n, wr_eff;

   assign req_op = req_instr_word[31:26];
   assign req_fn = req_instr_word[5:0];
   assign ra     = (req_op == OP_SPECIAL && req_fn == FN_SYSCALL) ? SYSCALL_REG
                                                                  : req_instr_word[25:21];

   assign op   = instr_ff[31:26];
   assign rt   = instr_ff[20:16];
   assign rd   = instr_ff[15:11];
   assign sa   = instr_ff[10:6];
   assign fn   = instr_ff[5:0];
   assign imm  = instr_ff[15:0];
   assign sext = {{16{imm[15]}}, imm};
   assign a    = a_vld_ff ? rf_a_ff : '0;
   assign b    = b_vld_ff ? rf_b_ff : '0;
   assign pc4  = pc_ff + 32'd4;
   assign btarget = pc4 + {sext[29:0], 2'b00};
   assign jt   = {pc4[31:28], instr_ff[25:0], 2'b00};
   assign ea   = a + sext;
   assign off  = ea - data_base_ff;

   // register file, read at accept
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         instr_ff <= req_instr_word;
         rf_a_ff  <= rf_mem[ra];
         rf_b_ff  <= rf_mem[req_instr_word[20:16]];
         a_vld_ff <= rf_vld_ff[ra];
         b_vld_ff <= rf_vld_ff[req_instr_word[20:16]];
      end
      if (cmd.wb_en && wr_eff) begin
         rf_mem[widx] <= wval;
      end
   end

   // execute stage
   assign mul_signed = (fn == FN_MULT);
   assign div_signed = (fn == FN_DIV);
   assign div_dnd    = (div_signed && a[31]) ? 32'(0 - a) : a;
   assign div_dvs    = (div_signed && b[31]) ? 32'(0 - b) : b;
   assign prod_full  = $signed({mul_signed & a[31], a}) * $signed({mul_signed & b[31], b});

   always_ff @(posedge clock) begin
      if (cmd.ex_en) begin
         ea_ff   <= ea;
         x_ff    <= off[31:2];
         prod_ff <= prod_full[63:0];
      end
      if (cmd.idx1_en) begin
         prod1_ff <= 62'({32'd0, x_ff} * {30'd0, RECIP});
      end
      if (cmd.idx2_en) begin
         r0_ff <= x_ff[AW:0] - (AW + 1)'(prod1_ff[61:32] * 30'(DATA_WORDS));
      end
   end

   assign idx_c = (r0_ff >= DEPTH) ? r0_ff - DEPTH : r0_ff;

   // data store
   always_ff @(posedge clock) begin
      if (cmd.clear_en) begin
         store_mem[clr_ff] <= '0;
      end else if (cmd.wb_en && st) begin
         store_mem[idx_ff] <= sval;
      end
      if (cmd.mrd_en) begin
         mem_ff <= store_mem[idx_c[AW-1:0]];
         idx_ff <= idx_c[AW-1:0];
      end
   end

   mie_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (div_dnd),
      .divisor   (div_dvs),
      .busy      (div_busy),
      .quotient  (div_q),
      .remainder (div_r)
   );

   assign bsh   = {ea_ff[1:0], 3'b000};
   assign hsh   = {ea_ff[1], 4'b0000};
   assign mem_b = mem_ff >> bsh;
   assign mem_h = mem_ff >> hsh;

   always_comb begin
      npc    = pc4;
      wr     = 1'b0;
      widx   = rt;
      wval   = '0;
      st     = 1'b0;
      mask   = '1;
      sdata  = b;
      hi_n   = hi_ff;
      lo_n   = lo_ff;
      stop_n = stopped_ff;
      if (stopped_ff) begin
         npc = pc_ff;
      end else begin
         case (op)
            OP_SPECIAL: begin
               wr   = 1'b1;
               widx = rd;
               case (fn)
                  FN_SLL:  wval = b << sa;
                  FN_SRL:  wval = b >> sa;
                  FN_SRA:  wval = 32'($signed(b) >>> sa);
                  FN_SLLV: wval = b << a[4:0];
                  FN_SRLV: wval = b >> a[4:0];
                  FN_SRAV: wval = 32'($signed(b) >>> a[4:0]);
                  FN_JR: begin
                     wr  = 1'b0;
                     npc = a;
                  end
                  FN_JALR: begin
                     wval = pc4;
                     npc  = a;
                  end
                  FN_SYSCALL: begin
                     wr = 1'b0;
                     if (a == HALT_CODE) begin
                        stop_n = 1'b1;
                     end
                  end
                  FN_MFHI: wval = hi_ff;
                  FN_MTHI: begin
                     wr   = 1'b0;
                     hi_n = a;
                  end
                  FN_MFLO: wval = lo_ff;
                  FN_MTLO: begin
                     wr   = 1'b0;
                     lo_n = a;
                  end
                  FN_MULT, FN_MULTU: begin
                     wr   = 1'b0;
                     hi_n = prod_ff[63:32];
                     lo_n = prod_ff[31:0];
                  end
                  FN_DIV, FN_DIVU: begin
                     wr = 1'b0;
                     if (b != '0) begin
                        lo_n = (div_signed && (a[31] ^ b[31])) ? 32'(0 - div_q) : div_q;
                        hi_n = (div_signed && a[31]) ? 32'(0 - div_r) : div_r;
                     end
                  end
                  FN_ADD, FN_ADDU: wval = a + b;
                  FN_SUB, FN_SUBU: wval = a - b;
                  FN_AND:  wval = a & b;
                  FN_OR:   wval = a | b;
                  FN_XOR:  wval = a ^ b;
                  FN_NOR:  wval = ~(a | b);
                  FN_SLT:  wval = {31'd0, $signed(a) < $signed(b)};
                  FN_SLTU: wval = {31'd0, a < b};
                  default: wr = 1'b0;
               endcase
            end
            OP_REGIMM: begin
               case (rt)
                  RI_BLTZ: begin
                     if (a[31]) npc = btarget;
                  end
                  RI_BGEZ: begin
                     if (!a[31]) npc = btarget;
                  end
                  RI_BLTZAL: begin
                     wr   = 1'b1;
                     widx = LINK_REG;
                     wval = pc4;
                     if (a[31]) npc = btarget;
                  end
                  RI_BGEZAL: begin
                     wr   = 1'b1;
                     widx = LINK_REG;
                     wval = pc4;
                     if (!a[31]) npc = btarget;
                  end
                  default: npc = pc4;
               endcase
            end
            OP_J: npc = jt;
            OP_JAL: begin
               wr   = 1'b1;
               widx = LINK_REG;
               wval = pc4;
               npc  = jt;
            end
            OP_BEQ: begin
               if (a == b) npc = btarget;
            end
            OP_BNE: begin
               if (a != b) npc = btarget;
            end
            OP_BLEZ: begin
               if (a == '0 || a[31]) npc = btarget;
            end
            OP_BGTZ: begin
               if (a != '0 && !a[31]) npc = btarget;
            end
            OP_ADDI, OP_ADDIU: begin
               wr   = 1'b1;
               wval = a + sext;
            end
            OP_SLTI: begin
               wr   = 1'b1;
               wval = {31'd0, $signed(a) < $signed(sext)};
            end
            OP_SLTIU: begin
               wr   = 1'b1;
               wval = {31'd0, a < sext};
            end
            OP_ANDI: begin
               wr   = 1'b1;
               wval = a & {16'd0, imm};
            end
            OP_ORI: begin
               wr   = 1'b1;
               wval = a | {16'd0, imm};
            end
            OP_XORI: begin
               wr   = 1'b1;
               wval = a ^ {16'd0, imm};
            end
            OP_LUI: begin
               wr   = 1'b1;
               wval = {imm, 16'd0};
            end
            OP_LB: begin
               wr   = 1'b1;
               wval = {{24{mem_b[7]}}, mem_b[7:0]};
            end
            OP_LH: begin
               wr   = 1'b1;
               wval = {{16{mem_h[15]}}, mem_h[15:0]};
            end
            OP_LW: begin
               wr   = 1'b1;
               wval = mem_ff;
            end
            OP_LBU: begin
               wr   = 1'b1;
               wval = {24'd0, mem_b[7:0]};
            end
            OP_LHU: begin
               wr   = 1'b1;
               wval = {16'd0, mem_h[15:0]};
            end
            OP_SB: begin
               st    = 1'b1;
               mask  = 32'h0000_00FF << bsh;
               sdata = {24'd0, b[7:0]} << bsh;
            end
            OP_SH: begin
               st    = 1'b1;
               mask  = 32'h0000_FFFF << hsh;
               sdata = {16'd0, b[15:0]} << hsh;
            end
            OP_SW: st = 1'b1;
            default: wr = 1'b0;
         endcase
      end
      sval   = (mem_ff & ~mask) | (sdata & mask);
      wr_eff = wr && (widx != '0);
   end

   // architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         rf_vld_ff    <= '0;
         pc_ff        <= RESET_PC;
         hi_ff        <= '0;
         lo_ff        <= '0;
         stopped_ff   <= 1'b0;
         data_base_ff <= RESET_DATA_BASE;
         clr_ff       <= '0;
      end else begin
         if (cmd.clear_en) begin
            clr_ff <= clr_ff + AW'(1);
         end
         if (csr_write && csr_index == CSR_DATA_BASE) begin
            data_base_ff <= csr_data;
         end
         if (cmd.wb_en) begin
            pc_ff      <= npc;
            hi_ff      <= hi_n;
            lo_ff      <= lo_n;
            stopped_ff <= stop_n;
            if (wr_eff) begin
               rf_vld_ff[widx] <= 1'b1;
            end
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.wb_en) begin
         rsp_next_pc       <= npc;
         rsp_halted        <= stop_n;
         rsp_reg_written   <= wr_eff;
         rsp_reg_index     <= wr_eff ? widx : '0;
         rsp_reg_value     <= wr_eff ? wval : '0;
         rsp_hi_value      <= hi_n;
         rsp_lo_value      <= lo_n;
         rsp_store_done    <= st;
         rsp_store_address <= st ? ea_ff : '0;
         rsp_store_value   <= st ? sval : '0;
      end
   end

   assign status.is_mem = !stopped_ff &&
      (op == OP_LB || op == OP_LH || op == OP_LW || op == OP_LBU || op == OP_LHU ||
       op == OP_SB || op == OP_SH || op == OP_SW);
   assign status.is_div = !stopped_ff && op == OP_SPECIAL && (fn == FN_DIV || fn == FN_DIVU);
   assign status.div_busy   = div_busy;
   assign status.clear_last = (clr_ff == LAST);

endmodule

[rtl/mie_ctrl.sv]
// ----------------------------------------------------------------------------
// MIPS instruction execute - controller
// Sequences store clearing, execute, address mapping, store read, divide and writeback.
// ----------------------------------------------------------------------------
`include "mips_instruction_execute_defines.svh"

module mie_ctrl import mie_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   input  mie_status_type status,
   output mie_cmd_type    cmd
);

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_EX    = 3'd2;
   localparam logic [2:0] S_IDX1  = 3'd3;
   localparam logic [2:0] S_IDX2  = 3'd4;
   localparam logic [2:0] S_MRD   = 3'd5;
   localparam logic [2:0] S_DIV   = 3'd6;
   localparam logic [2:0] S_WB    = 3'd7;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       slot_free;

   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear_en = 1'b1;
            if (status.clear_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            cmd.accept = req_valid;
            if (req_valid) state_in = S_EX;
         end
         S_EX: begin
            cmd.ex_en = 1'b1;
            if (status.is_div) begin
               cmd.div_start = 1'b1;
               state_in      = S_DIV;
            end else if (status.is_mem) begin
               state_in = S_IDX1;
            end else begin
               state_in = S_WB;
            end
         end
         S_IDX1: begin
            cmd.idx1_en = 1'b1;
            state_in    = S_IDX2;
         end
         S_IDX2: begin
            cmd.idx2_en = 1'b1;
            state_in    = S_MRD;
         end
         S_MRD: begin
            cmd.mrd_en = 1'b1;
            state_in   = S_WB;
         end
         S_DIV: begin
            if (!status.div_busy) state_in = S_WB;
         end
         S_WB: begin
            if (slot_free) begin
               cmd.wb_en = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid_in = cmd.wb_en | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   `MIE_ASSERT(a_wb_gives_rsp, cmd.wb_en |=> rsp_valid_ff, "writeback without result")
   `MIE_ASSERT(a_accept_to_ex, cmd.accept |=> state_ff == S_EX, "accept did not reach execute")
   `MIE_ASSERT(a_div_wait, (state_ff == S_DIV && status.div_busy) |=> state_ff == S_DIV,
      "left divide while busy")
   `MIE_ASSERT_ALWAYS(a_wb_accept_excl,
      reset || $onehot0({cmd.wb_en, cmd.accept, cmd.clear_en}), "overlapping commands")

endmodule
